[rtl/core/sed_pkg.sv]
// Shared types and constants of the string escape decoder.
package sed_pkg;

   localparam int unsigned FifoDepth = 4;
   localparam int unsigned PtrWidth  = $clog2(FifoDepth);
   localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharSquote    = 8'h27;
   localparam logic [7:0] CharDquote    = 8'h22;
   localparam logic [7:0] CharBs        = 8'h08;
   localparam logic [7:0] CharFf        = 8'h0C;
   localparam logic [7:0] CharLf        = 8'h0A;
   localparam logic [7:0] CharCr        = 8'h0D;
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [1:0] OctDigits     = 2'd3;

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_NORMAL = 5'b00010,
      MODE_ESC    = 5'b00100,
      MODE_HEX    = 5'b01000,
      MODE_OCT    = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first;
      logic       double_quote;
      logic       stream_end;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       closed;
      logic       unterminated;
      logic       last;
   } res_type;

   // up to two results per word, res0 goes out first
   typedef struct packed {
      logic [1:0] count;
      res_type    res0;
      res_type    res1;
   } step_out_type;

   typedef struct packed {
      logic [CntWidth-1:0] count;
      logic                space;
   } fifo_stat_type;

endpackage

[rtl/core/sed_step.sv]
// Escape decoding step: decoder state and the results of one word.
module sed_step import sed_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  item_type     item,
   output step_out_type step_out
);

   mode_type   mode_ff, mode_in;
   logic [7:0] accum_ff, accum_in;
   logic [1:0] oct_ff, oct_in;
   logic       term_dq_ff, term_dq_in;

   mode_type   mode_eff;
   logic [7:0] accum_eff;
   logic [1:0] oct_eff;
   logic       term_dq_eff;

   logic       pre_v;
   logic [7:0] pre_byte;
   logic       post_v;
   res_type    post_res;
   res_type    pre_res;
   logic [7:0] c;
   logic       hex_ok, oct_ok;
   logic [3:0] hex_d;
   logic [1:0] oct_next;
   logic [7:0] oct_acc;

   // terminator, backslash or plain byte in normal mode
   logic       nb_v;
   res_type    nb_res;
   mode_type   nb_mode;

   always_comb begin
      c           = item.in_byte;
      mode_eff    = item.first ? MODE_NORMAL : mode_ff;
      accum_eff   = item.first ? 8'd0 : accum_ff;
      oct_eff     = item.first ? 2'd0 : oct_ff;
      term_dq_eff = item.first ? item.double_quote : term_dq_ff;

      hex_ok = 1'b1;
      hex_d  = 4'd0;
      if (c >= "0" && c <= "9") begin
         hex_d = c[3:0];
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         hex_d = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
      oct_ok   = (c >= "0") && (c <= "7") && (oct_eff < OctDigits);
      oct_next = oct_eff + 2'd1;
      oct_acc  = {accum_eff[4:0], c[2:0]};

      nb_res  = '0;
      nb_v    = 1'b1;
      nb_mode = MODE_NORMAL;
      if (c == (term_dq_eff ? CharDquote : CharSquote)) begin
         nb_res.closed = 1'b1;
         nb_mode       = MODE_IDLE;
      end else if (c == CharBackslash) begin
         nb_v    = 1'b0;
         nb_mode = MODE_ESC;
      end else begin
         nb_res.out_byte   = c;
         nb_res.byte_valid = 1'b1;
      end

      pre_v      = 1'b0;
      pre_byte   = accum_eff;
      post_v     = 1'b0;
      post_res   = '0;
      mode_in    = mode_eff;
      accum_in   = accum_eff;
      oct_in     = oct_eff;
      term_dq_in = term_dq_eff;

      unique case (mode_eff)
         MODE_IDLE: begin
            mode_in = MODE_IDLE;
         end
         MODE_NORMAL, MODE_ESC, MODE_HEX, MODE_OCT: begin
            if (item.stream_end) begin
               pre_v                 = (mode_eff == MODE_HEX) || (mode_eff == MODE_OCT);
               post_v                = 1'b1;
               post_res.closed       = 1'b1;
               post_res.unterminated = 1'b1;
               mode_in               = MODE_IDLE;
               accum_in              = 8'd0;
               oct_in                = 2'd0;
            end else if (mode_eff == MODE_NORMAL) begin
               post_v   = nb_v;
               post_res = nb_res;
               mode_in  = nb_mode;
            end else if (mode_eff == MODE_ESC) begin
               mode_in             = MODE_NORMAL;
               post_v              = 1'b1;
               post_res.byte_valid = 1'b1;
               case (c)
                  "b":      post_res.out_byte = CharBs;
                  "f":      post_res.out_byte = CharFf;
                  "n":      post_res.out_byte = CharLf;
                  "r":      post_res.out_byte = CharCr;
                  "t":      post_res.out_byte = CharTab;
                  "x", "X": begin
                     post_v   = 1'b0;
                     post_res = '0;
                     accum_in = 8'd0;
                     mode_in  = MODE_HEX;
                  end
                  default: begin
                     if (c >= "0" && c <= "7") begin
                        post_v   = 1'b0;
                        post_res = '0;
                        accum_in = {5'd0, c[2:0]};
                        oct_in   = 2'd1;
                        mode_in  = MODE_OCT;
                     end else begin
                        post_res.out_byte = c;
                     end
                  end
               endcase
            end else if (mode_eff == MODE_HEX) begin
               if (hex_ok) begin
                  accum_in = {accum_eff[3:0], hex_d};
               end else begin
                  pre_v    = 1'b1;
                  accum_in = 8'd0;
                  post_v   = nb_v;
                  post_res = nb_res;
                  mode_in  = nb_mode;
               end
            end else begin
               if (oct_ok) begin
                  accum_in = oct_acc;
                  oct_in   = oct_next;
                  if (oct_next >= OctDigits) begin
                     // third digit completes the value
                     pre_v    = 1'b1;
                     pre_byte = oct_acc;
                     accum_in = 8'd0;
                     oct_in   = 2'd0;
                     mode_in  = MODE_NORMAL;
                  end
               end else begin
                  pre_v    = 1'b1;
                  accum_in = 8'd0;
                  oct_in   = 2'd0;
                  post_v   = nb_v;
                  post_res = nb_res;
                  mode_in  = nb_mode;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      pre_res            = '0;
      pre_res.out_byte   = pre_byte;
      pre_res.byte_valid = 1'b1;

      step_out       = '0;
      step_out.count = {1'b0, pre_v} + {1'b0, post_v};
      if (pre_v) begin
         step_out.res0      = pre_res;
         step_out.res0.last = !post_v;
         step_out.res1      = post_res;
         step_out.res1.last = 1'b1;
      end else begin
         step_out.res0      = post_res;
         step_out.res0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         accum_ff   <= 8'd0;
         oct_ff     <= 2'd0;
         term_dq_ff <= 1'b0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         accum_ff   <= accum_in;
         oct_ff     <= oct_in;
         term_dq_ff <= term_dq_in;
      end
   end

endmodule

[rtl/core/sed_result_fifo.sv]
// Result queue: takes up to two results per cycle, gives one per cycle while popped.
module sed_result_fifo import sed_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    push_count,
   input  res_type       push_res0,
   input  res_type       push_res1,
   output res_type       head,
   output logic          head_valid,
   input  logic          pop,
   output fifo_stat_type stat
);

   res_type             mem_ff [FifoDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_pop;

   always_comb begin
      do_pop     = pop && (count_ff != '0);
      wr_ptr_in  = wr_ptr_ff + PtrWidth'(push_count);
      rd_ptr_in  = rd_ptr_ff + PtrWidth'(do_pop);
      count_in   = count_ff + CntWidth'(push_count) - CntWidth'(do_pop);
      head       = mem_ff[rd_ptr_ff];
      head_valid = (count_ff != '0);
      stat.count = count_ff;
      // room for the worst case of two results
      stat.space = (count_ff <= CntWidth'(FifoDepth - 2));
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_res0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PtrWidth'(1)] <= push_res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/string_escape_decoder.sv]
// Top level of the string escape decoder: input register, decode step, result queue.
//
// Decodes the body of a quoted string literal, one byte per input word, and
// returns the decoded bytes and a close marker on the result stream. A word
// with tuser bit 0 set starts a new literal (tuser bit 1 picks the double
// quote as terminator, else the single quote); a word with tlast set ends the
// input, flushing any pending hex or octal escape and closing the literal as
// unterminated. Each input word yields zero, one or two result words; tlast
// marks the final result of the word that caused it. Throughput is one input
// word per cycle while each word yields at most one result and the result
// stream is not stalled; a hex or octal escape cut short by a byte other
// than a backslash, or by stream end, yields two results, which the single
// result port gives out one at a time. A result passes the input register,
// then the four-entry result queue, before it is offered. An input word is
// decoded only when the queue has room for two results.
module string_escape_decoder import sed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic [1:0] req_tuser,   // [0] first, [1] double_quote
   input  logic       req_tlast,   // stream_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [2:0] rsp_tuser,   // [0] byte_valid, [1] closed, [2] unterminated
   output logic       rsp_tlast    // last result of the input word
);

   // input register
   logic          in_valid_ff, in_valid_in;
   item_type      in_item_ff;
   logic          fire;
   logic          load;

   step_out_type  step_out;
   res_type       head;
   logic          head_valid;
   fifo_stat_type fstat;

   // decode a held word once the queue can take both possible results
   assign fire        = in_valid_ff && fstat.space;
   assign req_tready  = !in_valid_ff || fire;
   assign load        = req_tvalid && req_tready;
   assign in_valid_in = load || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_item_ff.in_byte      <= req_tdata;
         in_item_ff.first        <= req_tuser[0];
         in_item_ff.double_quote <= req_tuser[1];
         in_item_ff.stream_end   <= req_tlast;
      end
   end

   sed_step u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (in_item_ff),
      .step_out (step_out)
   );

   sed_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (fire ? step_out.count : 2'd0),
      .push_res0  (step_out.res0),
      .push_res1  (step_out.res1),
      .head       (head),
      .head_valid (head_valid),
      .pop        (rsp_tready),
      .stat       (fstat)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = {head.unterminated, head.closed, head.byte_valid};
   assign rsp_tlast  = head.last;

   // the queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= CntWidth'(FifoDepth))
      else $error("result queue over capacity");

   // a pair of results carries last only on the second word
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (fire && step_out.count == 2'd2) |-> (!step_out.res0.last && step_out.res1.last))
      else $error("last misplaced in result pair");

   // a result word is either a byte or a close, never both, and unterminated only with a close
   a_byte_or_close: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]) && (!rsp_tuser[2] || rsp_tuser[1]))
      else $error("result carries inconsistent flags");

   // nothing is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule
